FILE: hdl/pumlvp_pkg.sv
// Shared constants, codes and widths of the per-user memory limit victim picker.
package pumlvp_pkg;

    localparam int MAX_USERS_DEF          = 256;
    localparam int MAX_PROCS_PER_USER_DEF = 32;
    localparam int PAGE_BITS_DEF          = 12;

    // Kill results that one limit beat may produce.
    localparam int MAX_RESULTS = 32;
    localparam int KW          = $clog2(MAX_RESULTS + 1);

    localparam int UID_W   = 32;
    localparam int PID_W   = 22;
    localparam int PAGES_W = 24;
    localparam int LIMIT_W = 48;
    localparam int DELAY_W = 32;
    localparam int STEP_W  = 31;
    localparam int BYTES_W = 36;
    localparam int TOTAL_W = 41;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_PROC  = 2'd1,
        REQ_LIMIT = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_SKIPPED  = 3'd2,
        ST_DEFERRED = 3'd3,
        ST_NOACTION = 3'd4,
        ST_KILL     = 3'd5
    } status_t;

endpackage

FILE: hdl/per_user_memory_limit_victim_picker.sv
// Top level of the per-user memory limit victim picker: control sequencer and tables.
//
// Usage. A request beat is taken at a rising edge where start is high and busy is
// low. req_type selects begin scan, process record or limit entry. Every request
// answers with one or more result beats; each is shown for exactly one cycle with
// valid high, and last marks the final beat of a request. The receiver cannot
// stall, so results are never held back.
// The user table (uid, byte total, process count) and the process table
// (pid, bytes, one row of MAX_PROCS_PER_USER slots per user) sit in two
// synchronous RAMs with a registered read port.
// Begin scan, unknown requests and stopped or deferred limits show their result in
// the cycle right after the beat. A uid lookup reads and compares each entry in turn
// (S_U_RD, S_U_CMP), with one more S_U_RD when the uid is missing; a process record
// then passes S_ADD. Each kill scans the list (S_P_RD, S_P_CMP per entry, then S_P_RD
// and S_KILL) and compacts it (S_SH_RD, S_SH_WR per moved entry, S_SH_RD, S_SH_DONE).
// Throughput is one request at a time: busy is high while a lookup or kill loop
// runs, and a new beat may be taken at the edge that ends the final result beat or
// later. Begin scan sets step, clears stopped and rewinds the user count; the tables
// need no clearing after reset. Reset clears control state, user count, step, stopped.
module per_user_memory_limit_victim_picker #(
    parameter int MAX_USERS          = pumlvp_pkg::MAX_USERS_DEF,
    parameter int MAX_PROCS_PER_USER = pumlvp_pkg::MAX_PROCS_PER_USER_DEF,
    parameter int PAGE_BITS          = pumlvp_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic [pumlvp_pkg::UID_W-1:0]   uid,
    input  logic [pumlvp_pkg::PID_W-1:0]   pid,
    input  logic [pumlvp_pkg::PAGES_W-1:0] rss_pages,
    input  logic [pumlvp_pkg::LIMIT_W-1:0] limit_bytes,
    input  logic [pumlvp_pkg::DELAY_W-1:0] delay,
    input  logic [pumlvp_pkg::STEP_W-1:0]  scan_step,
    output logic                          valid,
    output logic [2:0]                    status,
    output logic [pumlvp_pkg::PID_W-1:0]   victim_pid,
    output logic [pumlvp_pkg::BYTES_W-1:0] victim_bytes,
    output logic [pumlvp_pkg::TOTAL_W-1:0] user_bytes,
    output logic [pumlvp_pkg::DELAY_W-1:0] new_delay,
    output logic                          last
);

    import pumlvp_pkg::*;

    localparam int UW   = $clog2(MAX_USERS);
    localparam int UCW  = $clog2(MAX_USERS + 1);
    localparam int PJW  = $clog2(MAX_PROCS_PER_USER);
    localparam int CW   = $clog2(MAX_PROCS_PER_USER + 1);
    localparam int UWID = UID_W + TOTAL_W + CW;
    localparam int PWID = PID_W + BYTES_W;
    localparam int PDEPTH = MAX_USERS * (2 ** PJW);

    typedef enum logic [3:0] {
        S_IDLE, S_U_RD, S_U_CMP, S_ADD, S_K_CHK, S_P_RD, S_P_CMP,
        S_KILL, S_SH_RD, S_SH_WR, S_SH_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]         req_reg, req_next;
    logic [UID_W-1:0]   uid_reg, uid_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [UCW-1:0]     idx_reg, idx_next;
    logic [UW-1:0]      uidx_reg, uidx_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [PJW-1:0]     best_reg, best_next;
    logic [BYTES_W-1:0] bestb_reg, bestb_next;
    logic [PID_W-1:0]   bestpid_reg, bestpid_next;
    logic [KW-1:0]      k_reg, k_next;
    logic               fin_reg, fin_next;
    logic [UCW-1:0]     users_reg, users_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               stopped_reg, stopped_next;

    logic               valid_reg, valid_next;
    logic [2:0]         status_reg, status_next;
    logic [PID_W-1:0]   vpid_reg, vpid_next;
    logic [BYTES_W-1:0] vbytes_reg, vbytes_next;
    logic [TOTAL_W-1:0] ubytes_reg, ubytes_next;
    logic [DELAY_W-1:0] ndelay_reg, ndelay_next;
    logic               last_reg, last_next;

    // Memory ports.
    logic            u_we;
    logic [UW-1:0]   u_waddr, u_raddr;
    logic [UWID-1:0] u_wdata, u_rdata;
    logic            p_we;
    logic [UW+PJW-1:0] p_waddr, p_raddr;
    logic [PWID-1:0] p_wdata, p_rdata;

    // Process bytes from pages, saturated to the byte field.
    logic [63:0]        pages_shifted;
    logic [BYTES_W-1:0] rec_bytes;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] sum_sat;
    logic [TOTAL_W-1:0] kill_total;
    logic [CW-1:0]      kill_cnt;
    logic [KW-1:0]      kill_k;
    logic [BYTES_W-1:0] rd_bytes;
    logic [PID_W-1:0]   rd_pid;

    assign pages_shifted = {40'd0, rss_pages} << PAGE_BITS;
    assign rec_bytes = (|pages_shifted[63:BYTES_W]) ? {BYTES_W{1'b1}}
                                                    : pages_shifted[BYTES_W-1:0];
    assign sum_wide  = {1'b0, total_reg} + {{(TOTAL_W + 1 - BYTES_W){1'b0}}, bytes_reg};
    assign sum_sat   = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
    assign kill_total = (total_reg >= {{(TOTAL_W - BYTES_W){1'b0}}, bestb_reg})
                      ? total_reg - {{(TOTAL_W - BYTES_W){1'b0}}, bestb_reg}
                      : '0;
    assign kill_cnt  = cnt_reg - CW'(1);
    assign kill_k    = k_reg + KW'(1);
    assign rd_pid    = p_rdata[PWID-1:BYTES_W];
    assign rd_bytes  = p_rdata[BYTES_W-1:0];

    pumlvp_ram #(.WIDTH(UWID), .DEPTH(MAX_USERS)) u_user_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    pumlvp_ram #(.WIDTH(PWID), .DEPTH(PDEPTH)) u_proc_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        uid_next     = uid_reg;
        pid_next     = pid_reg;
        bytes_next   = bytes_reg;
        limit_next   = limit_reg;
        idx_next     = idx_reg;
        uidx_next    = uidx_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        j_next       = j_reg;
        best_next    = best_reg;
        bestb_next   = bestb_reg;
        bestpid_next = bestpid_reg;
        k_next       = k_reg;
        fin_next     = fin_reg;
        users_next   = users_reg;
        step_next    = step_reg;
        stopped_next = stopped_reg;
        valid_next   = 1'b0;
        status_next  = status_reg;
        vpid_next    = '0;
        vbytes_next  = '0;
        ubytes_next  = '0;
        ndelay_next  = '0;
        last_next    = 1'b1;

        u_we    = 1'b0;
        u_waddr = uidx_reg;
        u_wdata = {uid_reg, total_reg, cnt_reg};
        u_raddr = idx_reg[UW-1:0];
        p_we    = 1'b0;
        p_waddr = {uidx_reg, j_reg[PJW-1:0]};
        p_wdata = {pid_reg, bytes_reg};
        p_raddr = {uidx_reg, j_reg[PJW-1:0]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    uid_next   = uid;
                    pid_next   = pid;
                    bytes_next = rec_bytes;
                    limit_next = limit_bytes;
                    idx_next   = '0;
                    k_next     = '0;
                    case (req_type)
                        REQ_BEGIN:
                        begin
                            users_next   = '0;
                            step_next    = scan_step;
                            stopped_next = 1'b0;
                            valid_next   = 1'b1;
                            status_next  = ST_ACCEPTED;
                        end
                        REQ_PROC:
                        begin
                            state_next = S_U_RD;
                        end
                        REQ_LIMIT:
                        begin
                            if (stopped_reg)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_SKIPPED;
                            end
                            else if (delay >= {1'b0, step_reg})
                            begin
                                stopped_next = 1'b1;
                                valid_next   = 1'b1;
                                status_next  = ST_DEFERRED;
                                ndelay_next  = delay - {1'b0, step_reg};
                            end
                            else
                            begin
                                state_next = S_U_RD;
                            end
                        end
                        default:
                        begin
                            valid_next  = 1'b1;
                            status_next = ST_NOACTION;
                        end
                    endcase
                end
            end
            S_U_RD:
            begin
                if (idx_reg == users_reg)
                begin
                    // The uid is not in the table.
                    if (req_reg == REQ_PROC)
                    begin
                        if (users_reg >= UCW'(MAX_USERS))
                        begin
                            valid_next  = 1'b1;
                            status_next = ST_DROPPED;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            uidx_next  = users_reg[UW-1:0];
                            users_next = users_reg + UCW'(1);
                            total_next = '0;
                            cnt_next   = '0;
                            state_next = S_ADD;
                        end
                    end
                    else
                    begin
                        valid_next  = 1'b1;
                        status_next = ST_NOACTION;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_U_CMP;
                end
            end
            S_U_CMP:
            begin
                if (u_rdata[UWID-1:TOTAL_W+CW] == uid_reg)
                begin
                    uidx_next  = idx_reg[UW-1:0];
                    total_next = u_rdata[TOTAL_W+CW-1:CW];
                    cnt_next   = u_rdata[CW-1:0];
                    state_next = (req_reg == REQ_PROC) ? S_ADD : S_K_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + UCW'(1);
                    state_next = S_U_RD;
                end
            end
            S_ADD:
            begin
                valid_next = 1'b1;
                state_next = S_IDLE;
                if (cnt_reg >= CW'(MAX_PROCS_PER_USER))
                begin
                    status_next = ST_DROPPED;
                end
                else
                begin
                    status_next = ST_ACCEPTED;
                    p_we    = 1'b1;
                    p_waddr = {uidx_reg, cnt_reg[PJW-1:0]};
                    u_we    = 1'b1;
                    u_wdata = {uid_reg, sum_sat, cnt_reg + CW'(1)};
                end
            end
            S_K_CHK:
            begin
                if (({{(LIMIT_W - TOTAL_W){1'b0}}, total_reg} >= limit_reg)
                    && (cnt_reg != '0))
                begin
                    j_next     = '0;
                    best_next  = '0;
                    bestb_next = '0;
                    state_next = S_P_RD;
                end
                else
                begin
                    valid_next  = 1'b1;
                    status_next = ST_NOACTION;
                    state_next  = S_IDLE;
                end
            end
            S_P_RD:
            begin
                state_next = (j_reg == cnt_reg) ? S_KILL : S_P_CMP;
            end
            S_P_CMP:
            begin
                // The first entry is always taken so an all-zero list picks it.
                if ((j_reg == '0) || (rd_bytes > bestb_reg))
                begin
                    best_next    = j_reg[PJW-1:0];
                    bestb_next   = rd_bytes;
                    bestpid_next = rd_pid;
                end
                j_next     = j_reg + CW'(1);
                state_next = S_P_RD;
            end
            S_KILL:
            begin
                valid_next  = 1'b1;
                status_next = ST_KILL;
                vpid_next   = bestpid_reg;
                vbytes_next = bestb_reg;
                ubytes_next = total_reg;
                fin_next    = !((kill_k < KW'(MAX_RESULTS))
                    && ({{(LIMIT_W - TOTAL_W){1'b0}}, kill_total} >= limit_reg)
                    && (kill_cnt != '0));
                last_next   = fin_next;
                total_next  = kill_total;
                cnt_next    = kill_cnt;
                k_next      = kill_k;
                j_next      = CW'({1'b0, best_reg}) + CW'(1);
                state_next  = S_SH_RD;
            end
            S_SH_RD:
            begin
                state_next = (j_reg > cnt_reg) ? S_SH_DONE : S_SH_WR;
            end
            S_SH_WR:
            begin
                p_we       = 1'b1;
                p_waddr    = {uidx_reg, PJW'(j_reg - CW'(1))};
                p_wdata    = p_rdata;
                j_next     = j_reg + CW'(1);
                state_next = S_SH_RD;
            end
            S_SH_DONE:
            begin
                u_we = 1'b1;
                if (fin_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = '0;
                    best_next  = '0;
                    bestb_next = '0;
                    state_next = S_P_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            users_reg   <= '0;
            step_reg    <= '0;
            stopped_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            users_reg   <= users_next;
            step_reg    <= step_next;
            stopped_reg <= stopped_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        uid_reg     <= uid_next;
        pid_reg     <= pid_next;
        bytes_reg   <= bytes_next;
        limit_reg   <= limit_next;
        idx_reg     <= idx_next;
        uidx_reg    <= uidx_next;
        total_reg   <= total_next;
        cnt_reg     <= cnt_next;
        j_reg       <= j_next;
        best_reg    <= best_next;
        bestb_reg   <= bestb_next;
        bestpid_reg <= bestpid_next;
        k_reg       <= k_next;
        fin_reg     <= fin_next;
        status_reg  <= status_next;
        vpid_reg    <= vpid_next;
        vbytes_reg  <= vbytes_next;
        ubytes_reg  <= ubytes_next;
        ndelay_reg  <= ndelay_next;
        last_reg    <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign valid        = valid_reg;
    assign status       = status_reg;
    assign victim_pid   = vpid_reg;
    assign victim_bytes = vbytes_reg;
    assign user_bytes   = ubytes_reg;
    assign new_delay    = ndelay_reg;
    assign last         = last_reg;

endmodule

FILE: hdl/pumlvp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module pumlvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
